// ===== sv/dbr_pkg.sv =====
// Shared types and constants of the DBCS bracket remover.
`default_nettype none
package dbr_pkg;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_OPEN_NARROW  = 2'd0;
  localparam logic [1:0] REG_CLOSE_NARROW = 2'd1;
  localparam logic [1:0] REG_OPEN_WIDE    = 2'd2;
  localparam logic [1:0] REG_CLOSE_WIDE   = 2'd3;

  // Reset codes: GBK parentheses.
  localparam logic [6:0]  RST_OPEN_NARROW  = 7'h28;
  localparam logic [6:0]  RST_CLOSE_NARROW = 7'h29;
  localparam logic [15:0] RST_OPEN_WIDE    = 16'hA3A8;
  localparam logic [15:0] RST_CLOSE_WIDE   = 16'hA3A9;

  typedef struct packed {
    logic [6:0]  open_narrow;
    logic [6:0]  close_narrow;
    logic [15:0] open_wide;
    logic [15:0] close_wide;
  } cfg_t;

  // Work record for one accepted byte: up to two kept bytes and an end marker.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [1:0] nbytes;
    logic       has_end;
    logic       changed;
  } rec_t;

endpackage
`default_nettype wire

// ===== sv/dbr_front.sv =====
// Front part: classifies each accepted byte and builds its work record.
`default_nettype none
module dbr_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [7:0]    in_byte,
  input  wire logic          last,
  input  wire dbr_pkg::cfg_t cfg,
  output dbr_pkg::rec_t      rec,
  output logic               rec_valid
);

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_HELD,
    MODE_NARROW,
    MODE_WIDE_FIRST,
    MODE_WIDE_SECOND
  } mode_t;

  mode_t       mode, mode_next;
  logic [7:0]  held_byte, held_byte_next;
  logic        removed_any, removed_any_next;
  logic [15:0] pair;

  assign pair = {held_byte, in_byte};

  always_comb begin
    mode_next        = mode;
    held_byte_next   = held_byte;
    removed_any_next = removed_any;
    rec              = '0;
    unique case (mode)
      MODE_HELD: begin
        if (pair == cfg.open_wide) begin
          removed_any_next = 1'b1;
          mode_next        = MODE_WIDE_FIRST;
        end else begin
          rec.b0     = held_byte;
          rec.b1     = in_byte;
          rec.nbytes = 2'd2;
          mode_next  = MODE_NORMAL;
        end
        held_byte_next = '0;
      end
      MODE_NARROW: begin
        if (in_byte == {1'b0, cfg.close_narrow}) begin
          mode_next = MODE_NORMAL;
        end
      end
      MODE_WIDE_FIRST: begin
        if (!last) begin
          held_byte_next = in_byte;
          mode_next      = MODE_WIDE_SECOND;
        end
      end
      MODE_WIDE_SECOND: begin
        mode_next      = (pair == cfg.close_wide) ? MODE_NORMAL : MODE_WIDE_FIRST;
        held_byte_next = '0;
      end
      default: begin
        if (in_byte[7]) begin
          // A lone high byte on the final position is dropped.
          if (!last) begin
            held_byte_next = in_byte;
            mode_next      = MODE_HELD;
          end
        end else if (in_byte == {1'b0, cfg.open_narrow}) begin
          removed_any_next = 1'b1;
          mode_next        = MODE_NARROW;
        end else begin
          rec.b0     = in_byte;
          rec.nbytes = 2'd1;
          mode_next  = MODE_NORMAL;
        end
      end
    endcase
    if (last) begin
      rec.has_end      = 1'b1;
      rec.changed      = removed_any_next;
      mode_next        = MODE_NORMAL;
      held_byte_next   = '0;
      removed_any_next = 1'b0;
    end
  end

  assign rec_valid = accept && ((rec.nbytes != 2'd0) || rec.has_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_NORMAL;
      held_byte   <= '0;
      removed_any <= 1'b0;
    end else if (accept) begin
      mode        <= mode_next;
      held_byte   <= held_byte_next;
      removed_any <= removed_any_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/dbr_queue.sv =====
// Record queue between the front and back parts.
`default_nettype none
module dbr_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire dbr_pkg::rec_t wr_data,
  input  wire logic          rd_en,
  output dbr_pkg::rec_t      rd_data,
  output logic               full,
  output logic               empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dbr_pkg::rec_t entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/dbr_back.sv =====
// Back part: expands the oldest work record into results, one per pop.
`default_nettype none
module dbr_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire dbr_pkg::rec_t rec,
  input  wire logic          rec_empty,
  output logic               rec_pop,
  input  wire logic          pop,
  output logic [7:0]         out_byte,
  output logic               is_end,
  output logic               changed
);

  logic [1:0] idx;
  logic [1:0] total;
  logic       final_result;
  logic       taken;

  assign total        = rec.nbytes + {1'b0, rec.has_end};
  assign final_result = ((idx + 2'd1) == total);
  assign taken        = pop && !rec_empty;
  assign rec_pop      = taken && final_result;

  always_comb begin
    if (idx < rec.nbytes) begin
      out_byte = (idx == 2'd0) ? rec.b0 : rec.b1;
      is_end   = 1'b0;
      changed  = 1'b0;
    end else begin
      out_byte = '0;
      is_end   = 1'b1;
      changed  = rec.changed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (taken) begin
      idx <= final_result ? 2'd0 : idx + 2'd1;
    end
  end

endmodule
`default_nettype wire

// ===== sv/dbcs_bracket_remover_top.sv =====
// Top level of the DBCS bracket remover: configuration port, front, queue and back.
// Accepted bytes' records are registered in the queue; results leave from its head.
// Throughput: one byte per cycle while the record queue has room; results leave
// one per cycle while pop is high; a kept pair or end marker needs several pops.
// The DEPTH-entry record queue absorbs those bursts before full rises.
// Reset clears the text mode, the queue and the result index, and loads GBK codes.
`default_nettype none
module dbcs_bracket_remover_top #(
  parameter int DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_byte,
  input  wire logic        last,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             is_end,
  output logic             changed,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  dbr_pkg::cfg_t cfg;
  dbr_pkg::rec_t front_rec, head_rec;
  logic          front_valid, head_pop;
  logic          accept, cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_narrow  <= dbr_pkg::RST_OPEN_NARROW;
      cfg.close_narrow <= dbr_pkg::RST_CLOSE_NARROW;
      cfg.open_wide    <= dbr_pkg::RST_OPEN_WIDE;
      cfg.close_wide   <= dbr_pkg::RST_CLOSE_WIDE;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        dbr_pkg::REG_OPEN_NARROW:  cfg.open_narrow  <= pwdata[6:0];
        dbr_pkg::REG_CLOSE_NARROW: cfg.close_narrow <= pwdata[6:0];
        dbr_pkg::REG_OPEN_WIDE:    cfg.open_wide    <= pwdata[15:0];
        dbr_pkg::REG_CLOSE_WIDE:   cfg.close_wide   <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      dbr_pkg::REG_OPEN_NARROW:  prdata = {25'd0, cfg.open_narrow};
      dbr_pkg::REG_CLOSE_NARROW: prdata = {25'd0, cfg.close_narrow};
      dbr_pkg::REG_OPEN_WIDE:    prdata = {16'd0, cfg.open_wide};
      dbr_pkg::REG_CLOSE_WIDE:   prdata = {16'd0, cfg.close_wide};
    endcase
  end

  dbr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .last      (last),
    .cfg       (cfg),
    .rec       (front_rec),
    .rec_valid (front_valid)
  );

  dbr_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_valid),
    .wr_data (front_rec),
    .rd_en   (head_pop),
    .rd_data (head_rec),
    .full    (full),
    .empty   (empty)
  );

  dbr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec       (head_rec),
    .rec_empty (empty),
    .rec_pop   (head_pop),
    .pop       (pop),
    .out_byte  (out_byte),
    .is_end    (is_end),
    .changed   (changed)
  );

  // The end marker carries no byte.
  a_end_zero : assert property (@(posedge clk) disable iff (rst)
    (!empty && is_end) |-> (out_byte == 8'd0))
    else $error("end marker with nonzero byte");

  // Only the end marker reports removed text.
  a_changed_end : assert property (@(posedge clk) disable iff (rst)
    (!empty && !is_end) |-> !changed)
    else $error("changed set on a byte result");

  // Nothing is waiting right after reset.
  a_reset_empty : assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queue not empty after reset");

  // With no request on either side the queue level holds.
  a_idle_hold : assert property (@(posedge clk) disable iff (rst)
    (!push && !pop) |=> ($stable(empty) && $stable(full)))
    else $error("queue level moved while idle");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench of the DBCS bracket remover top level.
module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 8;

  typedef struct packed {
    logic [7:0] ob;
    logic       fin;
    logic       chg;
  } out_t;

  typedef struct packed {
    logic [7:0] b;
    logic       l;
    logic [1:0] nt;
    out_t       t0;
    out_t       t1;
  } row_t;

  typedef enum logic [2:0] {
    M_TEXT, M_PAIR, M_NARROW, M_WIDE_FIRST, M_WIDE_SECOND
  } mode_e;

  typedef enum int {
    T_ASCII, T_OPEN_N, T_CLOSE_N, T_PAIR, T_OPEN_W, T_CLOSE_W, T_NOISE, T_HIGH
  } tok_e;

  localparam out_t NIL  = '{8'h00, 1'b0, 1'b0};
  localparam out_t END0 = '{8'h00, 1'b1, 1'b0};
  localparam out_t END1 = '{8'h00, 1'b1, 1'b1};

  // Rows with nt of zero are checked against the predictor only.
  row_t dir_rows [0:23] = '{
    '{8'h41, 1'b0, 2'd1, '{8'h41, 1'b0, 1'b0}, NIL},
    '{8'h01, 1'b0, 2'd1, '{8'h01, 1'b0, 1'b0}, NIL},
    '{8'h28, 1'b0, 2'd0, NIL, NIL},
    '{8'hFF, 1'b0, 2'd0, NIL, NIL},
    '{8'h29, 1'b0, 2'd0, NIL, NIL},
    '{8'h29, 1'b0, 2'd1, '{8'h29, 1'b0, 1'b0}, NIL},
    '{8'hA3, 1'b0, 2'd0, NIL, NIL},
    '{8'hA8, 1'b0, 2'd0, NIL, NIL},
    '{8'hB0, 1'b0, 2'd0, NIL, NIL},
    '{8'hA1, 1'b0, 2'd0, NIL, NIL},
    '{8'hA3, 1'b0, 2'd0, NIL, NIL},
    '{8'hA9, 1'b0, 2'd0, NIL, NIL},
    '{8'hC4, 1'b0, 2'd0, NIL, NIL},
    '{8'hE3, 1'b0, 2'd0, NIL, NIL},
    '{8'h7F, 1'b1, 2'd0, NIL, NIL},
    '{8'h42, 1'b1, 2'd2, '{8'h42, 1'b0, 1'b0}, END0},
    '{8'hFF, 1'b1, 2'd1, END0, NIL},
    '{8'h28, 1'b1, 2'd1, END1, NIL},
    '{8'hA3, 1'b0, 2'd0, NIL, NIL},
    '{8'hA8, 1'b0, 2'd0, NIL, NIL},
    '{8'hB0, 1'b1, 2'd1, END1, NIL},
    '{8'h80, 1'b0, 2'd0, NIL, NIL},
    '{8'h80, 1'b1, 2'd0, NIL, NIL},
    '{8'h00, 1'b1, 2'd2, '{8'h00, 1'b0, 1'b0}, END0}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [7:0]  in_byte = 8'h00;
  logic        last = 1'b0;
  logic        pop = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'h0;
  logic [31:0] pwdata = 32'h0;
  logic        full;
  logic        empty;
  logic [7:0]  out_byte;
  logic        is_end;
  logic        changed;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the bracket codes and of the text state.
  logic [6:0]  on_c = dbr_pkg::RST_OPEN_NARROW;
  logic [6:0]  cn_c = dbr_pkg::RST_CLOSE_NARROW;
  logic [15:0] ow_c = dbr_pkg::RST_OPEN_WIDE;
  logic [15:0] cw_c = dbr_pkg::RST_CLOSE_WIDE;
  mode_e       mode = M_TEXT;
  logic [7:0]  held = 8'h00;
  logic        removed = 1'b0;

  out_t kept_q [$];
  int   errors = 0;
  int   cycles = 0;
  int   n_items = 0;
  int   n_strings = 0;
  int   n_checked = 0;
  int   n_writes = 0;
  int   snd_pct = 0;
  int   rcv_pct = 0;

  dbcs_bracket_remover_top dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .in_byte(in_byte), .last(last),
    .empty(empty), .pop(pop), .out_byte(out_byte), .is_end(is_end), .changed(changed),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, kept_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: compares each popped result with the oldest predicted one.
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (kept_q.size() == 0) begin
          $display("%0t: unexpected result out_byte %h is_end %b changed %b",
                   $time, out_byte, is_end, changed);
          errors++;
        end else begin
          want = kept_q.pop_front();
          n_checked++;
          if (out_byte !== want.ob) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.ob, out_byte);
            errors++;
          end
          if (is_end !== want.fin) begin
            $display("%0t: is_end expected %b actual %b", $time, want.fin, is_end);
            errors++;
          end
          if (changed !== want.chg) begin
            $display("%0t: changed expected %b actual %b", $time, want.chg, changed);
            errors++;
          end
        end
      end
      pop <= ($urandom_range(0, 99) >= rcv_pct);
    end
  end

  // Advances the shadow state by one accepted byte; keep adds its results to kept_q.
  task automatic strip_byte(input logic [7:0] b, input logic l, input bit keep);
    logic [15:0] pair;
    out_t        res [$];
    pair = {held, b};
    case (mode)
      M_PAIR: begin
        if (pair == ow_c) begin
          removed = 1'b1;
          mode = M_WIDE_FIRST;
        end else begin
          res.insert(res.size(), out_t'{held, 1'b0, 1'b0});
          res.insert(res.size(), out_t'{b, 1'b0, 1'b0});
          mode = M_TEXT;
        end
        held = 8'h00;
      end
      M_NARROW: begin
        if (b == {1'b0, cn_c}) mode = M_TEXT;
      end
      M_WIDE_FIRST: begin
        if (!l) begin
          held = b;
          mode = M_WIDE_SECOND;
        end
      end
      M_WIDE_SECOND: begin
        mode = (pair == cw_c) ? M_TEXT : M_WIDE_FIRST;
        held = 8'h00;
      end
      default: begin
        if (b[7]) begin
          // A first byte that carries last is dropped.
          if (!l) begin
            held = b;
            mode = M_PAIR;
          end
        end else if (b[6:0] == on_c) begin
          removed = 1'b1;
          mode = M_NARROW;
        end else begin
          res.insert(res.size(), out_t'{b, 1'b0, 1'b0});
        end
      end
    endcase
    if (l) begin
      res.insert(res.size(), out_t'{8'h00, 1'b1, removed});
      mode = M_TEXT;
      held = 8'h00;
      removed = 1'b0;
    end
    if (keep) foreach (res[i]) kept_q.insert(kept_q.size(), res[i]);
  endtask

  // Returns at the clock edge at which the request is taken.
  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(0, 99) < snd_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    last <= l;
    @(posedge clk);
    while (full) @(posedge clk);
    n_items++;
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (kept_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes one register, then reads it back.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] v);
    logic [31:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      dbr_pkg::REG_OPEN_NARROW:  on_c = v[6:0];
      dbr_pkg::REG_CLOSE_NARROW: cn_c = v[6:0];
      dbr_pkg::REG_OPEN_WIDE:    ow_c = v[15:0];
      default:                   cw_c = v[15:0];
    endcase
    n_writes++;
    case (idx)
      dbr_pkg::REG_OPEN_NARROW:  want = {25'd0, on_c};
      dbr_pkg::REG_CLOSE_NARROW: want = {25'd0, cn_c};
      dbr_pkg::REG_OPEN_WIDE:    want = {16'd0, ow_c};
      default:                   want = {16'd0, cw_c};
    endcase
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      $display("%0t: register %0d read expected %h actual %h", $time, idx, want, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_codes(input logic [31:0] on, input logic [31:0] cn,
                           input logic [31:0] ow, input logic [31:0] cw);
    reg_write(dbr_pkg::REG_OPEN_NARROW, on);
    reg_write(dbr_pkg::REG_CLOSE_NARROW, cn);
    reg_write(dbr_pkg::REG_OPEN_WIDE, ow);
    reg_write(dbr_pkg::REG_CLOSE_WIDE, cw);
  endtask

  // Builds one string out of characters, brackets and noise and sends it.
  task automatic send_string();
    logic [7:0] bq [$];
    int         ntok;
    int         k;
    tok_e       kind;
    ntok = $urandom_range(1, 6);
    repeat (ntok) begin
      k = $urandom_range(0, 9);
      kind = (k > 7) ? T_ASCII : tok_e'(k);
      case (kind)
        T_ASCII:   bq.insert(bq.size(), 8'($urandom_range(1, 127)));
        T_OPEN_N:  bq.insert(bq.size(), {1'b0, on_c});
        T_CLOSE_N: bq.insert(bq.size(), {1'b0, cn_c});
        T_PAIR: begin
          bq.insert(bq.size(), 8'($urandom_range(128, 255)));
          bq.insert(bq.size(), 8'($urandom_range(1, 255)));
        end
        T_OPEN_W: begin
          bq.insert(bq.size(), ow_c[15:8]);
          bq.insert(bq.size(), ow_c[7:0]);
        end
        T_CLOSE_W: begin
          bq.insert(bq.size(), cw_c[15:8]);
          bq.insert(bq.size(), cw_c[7:0]);
        end
        T_HIGH:    bq.insert(bq.size(), 8'($urandom_range(128, 255)));
        default:   bq.insert(bq.size(), 8'($urandom_range(1, 255)));
      endcase
    end
    foreach (bq[i]) begin
      send_byte(bq[i], i == bq.size() - 1);
      strip_byte(bq[i], i == bq.size() - 1, 1'b1);
    end
    n_strings++;
  endtask

  initial begin
    int          done;
    logic [31:0] rnd_ow;
    logic [31:0] rnd_cw;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].b, dir_rows[i].l);
      strip_byte(dir_rows[i].b, dir_rows[i].l, dir_rows[i].nt == 2'd0);
      if (dir_rows[i].nt != 2'd0) kept_q.insert(kept_q.size(), dir_rows[i].t0);
      if (dir_rows[i].nt == 2'd2) kept_q.insert(kept_q.size(), dir_rows[i].t1);
    end

    for (int p = 0; p < 8; p++) begin
      if (p % 2 == 0) begin
        wait_idle();
        case (p / 2)
          0: set_codes(dbr_pkg::RST_OPEN_NARROW, dbr_pkg::RST_CLOSE_NARROW,
                       dbr_pkg::RST_OPEN_WIDE, dbr_pkg::RST_CLOSE_WIDE);
          1: set_codes(32'h0, 32'hFFFF_FF7F, 32'h0000_FFFF, 32'hABCD_8000);
          // An open code with a low first byte can never be matched.
          2: set_codes(32'h7F, 32'h0000_0080, 32'h0000_2829, 32'h0000_FFFF);
          default: begin
            rnd_ow = $urandom;
            rnd_cw = $urandom;
            rnd_ow[15] = 1'b1;
            rnd_cw[15] = 1'b1;
            set_codes($urandom, $urandom, rnd_ow, rnd_cw);
          end
        endcase
      end
      case (p % 4)
        0: begin snd_pct = 0;  rcv_pct = 0;  end
        1: begin snd_pct = 55; rcv_pct = 0;  end
        2: begin snd_pct = 0;  rcv_pct = 55; end
        default: begin snd_pct = 26; rcv_pct = 26; end
      endcase
      done = n_items + 8;
      while (n_items < done) begin
        send_string();
        // Now and then hold off until the block has drained completely.
        if (n_strings % 5 == 4) wait_idle();
      end
    end

    wait_idle();
    $display("Sent %0d bytes in %0d random strings plus directed rows; %0d results checked.",
             n_items, n_strings, n_checked);
    $display("Four sets of bracket codes via %0d register writes, four idle patterns.",
             n_writes);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/dbr_pkg.sv
sv/dbr_front.sv
sv/dbr_queue.sv
sv/dbr_back.sv
sv/dbcs_bracket_remover_top.sv
tb/tb.sv
